// ===== rtl/core/gcd_pkg.sv =====
package gcd_pkg;

    // Gesture state codes
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_ONE    = 2'd1;
    localparam logic [1:0] ST_TWO    = 2'd2;
    localparam logic [1:0] ST_OTHERS = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] REG_ONE_HOLD      = 3'd0;
    localparam logic [2:0] REG_NONE_HOLD     = 3'd1;
    localparam logic [2:0] REG_TWO_HOLD      = 3'd2;
    localparam logic [2:0] REG_EARLY_ONE_LVL = 3'd3;
    localparam logic [2:0] REG_EARLY_TWO_LVL = 3'd4;
    localparam logic [2:0] REG_OTHERS_HOLD   = 3'd5;

    localparam int CFG_BITS  = 8;
    localparam int IDX_BITS  = 3;
    localparam int DATA_BITS = 8;

    // Register reset values
    localparam logic [CFG_BITS-1:0] RST_ONE_HOLD      = 8'd8;
    localparam logic [CFG_BITS-1:0] RST_NONE_HOLD     = 8'd5;
    localparam logic [CFG_BITS-1:0] RST_TWO_HOLD      = 8'd10;
    localparam logic [CFG_BITS-1:0] RST_EARLY_ONE_LVL = 8'd5;
    localparam logic [CFG_BITS-1:0] RST_EARLY_TWO_LVL = 8'd5;
    localparam logic [CFG_BITS-1:0] RST_OTHERS_HOLD   = 8'd5;

    typedef struct packed {
        logic [CFG_BITS-1:0] one_hold;
        logic [CFG_BITS-1:0] none_hold;
        logic [CFG_BITS-1:0] two_hold;
        logic [CFG_BITS-1:0] early_one_lvl;
        logic [CFG_BITS-1:0] early_two_lvl;
        logic [CFG_BITS-1:0] others_hold;
    } t_cfg;

endpackage

// ===== rtl/core/gesture_count_debouncer.sv =====
// Gesture count debouncer.
// Input stream s_axis: one beat per video frame, tdata[3:0] = finger count.
// Output stream m_axis: one beat per input beat, tdata[1:0] = gesture state
// (0 idle, 1 one finger, 2 two fingers, 3 others), in input order.
// The frame counters and gesture state update in the cycle a beat is accepted;
// its result goes to the output register, or to the skid register on a stall.
// Throughput: one beat per cycle while the skid register is empty.
// An output register plus a one-beat skid register let one more beat in while
// a result waits; s_axis_tready drops only when both are full, and rises again
// the cycle after m_axis drains a beat.
// Thresholds are written through i_cfg_wr_en / i_cfg_index / i_cfg_data,
// which take effect on the next accepted beat; write only while idle.
// Synchronous active-low reset restores default thresholds (8,5,10,5,5,5),
// clears the counters, sets the state to idle and empties both output stages.
module gesture_count_debouncer #(
    parameter int COUNTER_BITS = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [7:0]                         s_axis_tdata,  // [3:0] finger_count
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [7:0]                         m_axis_tdata,  // [1:0] gesture_state
    input  logic                               i_cfg_wr_en,
    input  logic [gcd_pkg::IDX_BITS-1:0]       i_cfg_index,
    input  logic [gcd_pkg::DATA_BITS-1:0]      i_cfg_data
);
    import gcd_pkg::*;

    t_cfg r_cfg;

    logic [COUNTER_BITS-1:0] r_none_frames, n_none_frames;
    logic [COUNTER_BITS-1:0] r_one_frames,  n_one_frames;
    logic [COUNTER_BITS-1:0] r_two_frames,  n_two_frames;
    logic [COUNTER_BITS-1:0] r_other_frames, n_other_frames;
    logic [1:0]              r_gesture, n_gesture;

    logic       r_out_valid;
    logic [1:0] r_out_data;
    logic       r_skid_valid;
    logic [1:0] r_skid_data;

    logic w_accept;
    logic w_out_free;

    assign s_axis_tready = !r_skid_valid;
    assign w_accept      = s_axis_tvalid && !r_skid_valid;
    assign w_out_free    = !r_out_valid || m_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out_data};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.one_hold      <= RST_ONE_HOLD;
            r_cfg.none_hold     <= RST_NONE_HOLD;
            r_cfg.two_hold      <= RST_TWO_HOLD;
            r_cfg.early_one_lvl <= RST_EARLY_ONE_LVL;
            r_cfg.early_two_lvl <= RST_EARLY_TWO_LVL;
            r_cfg.others_hold   <= RST_OTHERS_HOLD;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_ONE_HOLD:      r_cfg.one_hold      <= i_cfg_data;
                REG_NONE_HOLD:     r_cfg.none_hold     <= i_cfg_data;
                REG_TWO_HOLD:      r_cfg.two_hold      <= i_cfg_data;
                REG_EARLY_ONE_LVL: r_cfg.early_one_lvl <= i_cfg_data;
                REG_EARLY_TWO_LVL: r_cfg.early_two_lvl <= i_cfg_data;
                REG_OTHERS_HOLD:   r_cfg.others_hold   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    gcd_update #(
        .COUNTER_BITS(COUNTER_BITS)
    ) u_update (
        .i_finger_count(s_axis_tdata[3:0]),
        .i_cfg         (r_cfg),
        .i_none_frames (r_none_frames),
        .i_one_frames  (r_one_frames),
        .i_two_frames  (r_two_frames),
        .i_other_frames(r_other_frames),
        .i_gesture     (r_gesture),
        .o_none_frames (n_none_frames),
        .o_one_frames  (n_one_frames),
        .o_two_frames  (n_two_frames),
        .o_other_frames(n_other_frames),
        .o_gesture     (n_gesture)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_none_frames  <= '0;
            r_one_frames   <= '0;
            r_two_frames   <= '0;
            r_other_frames <= '0;
            r_gesture      <= ST_IDLE;
        end else if (w_accept) begin
            r_none_frames  <= n_none_frames;
            r_one_frames   <= n_one_frames;
            r_two_frames   <= n_two_frames;
            r_other_frames <= n_other_frames;
            r_gesture      <= n_gesture;
        end
    end

    // Output register with a one-beat skid behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid  <= r_skid_valid || w_accept;
            r_skid_valid <= 1'b0;
        end else if (w_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            r_out_data <= r_skid_valid ? r_skid_data : n_gesture;
        end else if (w_accept) begin
            r_skid_data <= n_gesture;
        end
    end

endmodule

// ===== rtl/core/gcd_update.sv =====
module gcd_update #(
    parameter int COUNTER_BITS = 8
) (
    input  logic [3:0]              i_finger_count,
    input  gcd_pkg::t_cfg           i_cfg,
    input  logic [COUNTER_BITS-1:0] i_none_frames,
    input  logic [COUNTER_BITS-1:0] i_one_frames,
    input  logic [COUNTER_BITS-1:0] i_two_frames,
    input  logic [COUNTER_BITS-1:0] i_other_frames,
    input  logic [1:0]              i_gesture,
    output logic [COUNTER_BITS-1:0] o_none_frames,
    output logic [COUNTER_BITS-1:0] o_one_frames,
    output logic [COUNTER_BITS-1:0] o_two_frames,
    output logic [COUNTER_BITS-1:0] o_other_frames,
    output logic [1:0]              o_gesture
);
    import gcd_pkg::*;

    localparam int CMP_BITS = (COUNTER_BITS > CFG_BITS) ? COUNTER_BITS : CFG_BITS;
    localparam logic [COUNTER_BITS-1:0] CNT_MAX = {COUNTER_BITS{1'b1}};
    localparam logic [COUNTER_BITS-1:0] CNT_ONE = COUNTER_BITS'(1);

    function automatic logic [COUNTER_BITS-1:0] sat_inc(input logic [COUNTER_BITS-1:0] c);
        return (c == CNT_MAX) ? c : c + CNT_ONE;
    endfunction

    // Compare in a common width so a level above the counter range never matches
    function automatic logic reached(input logic [COUNTER_BITS-1:0] c,
                                     input logic [CFG_BITS-1:0] lvl);
        return CMP_BITS'(c) >= CMP_BITS'(lvl);
    endfunction

    logic [COUNTER_BITS-1:0] w_none_inc;
    logic [COUNTER_BITS-1:0] w_one_inc;
    logic [COUNTER_BITS-1:0] w_two_inc;
    logic [COUNTER_BITS-1:0] w_other_inc;

    assign w_none_inc  = sat_inc(i_none_frames);
    assign w_one_inc   = sat_inc(i_one_frames);
    assign w_two_inc   = sat_inc(i_two_frames);
    assign w_other_inc = sat_inc(i_other_frames);

    always_comb begin
        o_none_frames  = i_none_frames;
        o_one_frames   = i_one_frames;
        o_two_frames   = i_two_frames;
        o_other_frames = i_other_frames;
        o_gesture      = i_gesture;
        case (i_finger_count)
            4'd0: begin
                o_none_frames = w_none_inc;
                if (reached(w_none_inc, i_cfg.none_hold)) begin
                    o_one_frames   = '0;
                    o_other_frames = '0;
                    o_gesture      = ST_IDLE;
                end
            end
            4'd1: begin
                o_one_frames = w_one_inc;
                if (reached(w_one_inc, i_cfg.one_hold)) begin
                    o_none_frames  = '0;
                    o_two_frames   = '0;
                    o_other_frames = '0;
                    o_gesture      = ST_ONE;
                end
            end
            4'd2: begin
                o_two_frames = w_two_inc;
                if (reached(w_two_inc, i_cfg.two_hold) ||
                    (reached(i_one_frames, i_cfg.early_one_lvl) &&
                     reached(w_two_inc, i_cfg.early_two_lvl))) begin
                    o_none_frames  = '0;
                    o_one_frames   = '0;
                    o_other_frames = '0;
                    o_gesture      = ST_TWO;
                end
            end
            default: begin
                o_other_frames = w_other_inc;
                if (reached(w_other_inc, i_cfg.others_hold)) begin
                    o_none_frames = '0;
                    o_one_frames  = '0;
                    o_gesture     = ST_OTHERS;
                end
            end
        endcase
    end

endmodule

// ===== rtl/core/gcd_checker.sv =====
module gcd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);

    // Stalled output beat holds its data
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled output beat changed");

    // Nothing is presented right after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // Backpressure only when a result is waiting on the output
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with empty output");

    // Full skid cannot drain while the output is stalled
    a_skid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!s_axis_tready && !m_axis_tready) |=> !s_axis_tready)
        else $error("skid drained during output stall");

    // A beat taken into a full output stage keeps the next result pending
    a_accept_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && m_axis_tvalid && !m_axis_tready)
        |=> !s_axis_tready)
        else $error("second beat not held during stall");

endmodule

bind gesture_count_debouncer gcd_checker u_gcd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
);

// ===== tb/sv/tb_gesture_count_debouncer.sv =====
`timescale 1ns / 1ps

module tb_gesture_count_debouncer;
    import gcd_pkg::*;

    localparam int CNT_BITS       = 8;
    localparam int PHASES         = 10;
    localparam int FRAMES_PER_PHS = 200;
    localparam int STALL_LIMIT    = 2000;
    localparam int IDLE_PCT       = 36;
    localparam int QUIET_PHASE    = 5;

    // Indexes past the last register: writes to them must be dropped
    localparam logic [IDX_BITS-1:0] REG_UNUSED_A = 3'd6;
    localparam logic [IDX_BITS-1:0] REG_UNUSED_B = 3'd7;

    class gesture_scoreboard;
        logic [CFG_BITS-1:0] hold [6];
        logic [CNT_BITS-1:0] none_cnt, one_cnt, two_cnt, other_cnt;
        logic [1:0]          gest;
        logic [1:0]          state_q [$];
        int                  errors;
        int                  frames;
        int                  checked;
        int                  seen [4];

        function new();
            hold[REG_ONE_HOLD]      = RST_ONE_HOLD;
            hold[REG_NONE_HOLD]     = RST_NONE_HOLD;
            hold[REG_TWO_HOLD]      = RST_TWO_HOLD;
            hold[REG_EARLY_ONE_LVL] = RST_EARLY_ONE_LVL;
            hold[REG_EARLY_TWO_LVL] = RST_EARLY_TWO_LVL;
            hold[REG_OTHERS_HOLD]   = RST_OTHERS_HOLD;
            none_cnt  = '0;
            one_cnt   = '0;
            two_cnt   = '0;
            other_cnt = '0;
            gest      = ST_IDLE;
            errors    = 0;
            frames    = 0;
            checked   = 0;
            foreach (seen[i]) seen[i] = 0;
        endfunction

        function void set_reg(logic [IDX_BITS-1:0] idx, logic [DATA_BITS-1:0] val);
            if (idx <= REG_OTHERS_HOLD)
                hold[idx] = val;
        endfunction

        function logic [CNT_BITS-1:0] bump(logic [CNT_BITS-1:0] c);
            return (c == {CNT_BITS{1'b1}}) ? c : c + 1'b1;
        endfunction

        function void note_frame(logic [3:0] fingers);
            frames++;
            case (fingers)
                4'd1: begin
                    one_cnt = bump(one_cnt);
                    if (one_cnt >= hold[REG_ONE_HOLD]) begin
                        none_cnt  = '0;
                        two_cnt   = '0;
                        other_cnt = '0;
                        gest      = ST_ONE;
                    end
                end
                4'd0: begin
                    none_cnt = bump(none_cnt);
                    if (none_cnt >= hold[REG_NONE_HOLD]) begin
                        one_cnt   = '0;
                        other_cnt = '0;
                        gest      = ST_IDLE;
                    end
                end
                4'd2: begin
                    two_cnt = bump(two_cnt);
                    if (two_cnt >= hold[REG_TWO_HOLD] ||
                        (one_cnt >= hold[REG_EARLY_ONE_LVL] &&
                         two_cnt >= hold[REG_EARLY_TWO_LVL])) begin
                        none_cnt  = '0;
                        one_cnt   = '0;
                        other_cnt = '0;
                        gest      = ST_TWO;
                    end
                end
                default: begin
                    other_cnt = bump(other_cnt);
                    if (other_cnt >= hold[REG_OTHERS_HOLD]) begin
                        none_cnt = '0;
                        one_cnt  = '0;
                        gest     = ST_OTHERS;
                    end
                end
            endcase
            state_q = {state_q, gest};
        endfunction

        function void check_state(logic [1:0] actual);
            logic [1:0] expected;
            if (state_q.size() == 0) begin
                $error("gesture_state beat with no frame pending: actual %0d", actual);
                errors++;
                return;
            end
            expected = state_q.pop_front();
            checked++;
            seen[expected]++;
            if (actual !== expected) begin
                $error("gesture_state mismatch: expected %0d, actual %0d", expected, actual);
                errors++;
            end
        endfunction

        function int pending();
            return state_q.size();
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata = 8'd0;   // [3:0] finger_count
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [7:0]            m_axis_tdata;          // [1:0] gesture_state
    logic                  i_cfg_wr_en = 1'b0;
    logic [IDX_BITS-1:0]   i_cfg_index = '0;
    logic [DATA_BITS-1:0]  i_cfg_data = '0;

    gesture_scoreboard sb = new();
    bit  in_idle_on  = 1'b1;
    bit  out_idle_on = 1'b1;
    int  stall_cycles = 0;
    int  settings = 0;

    gesture_count_debouncer dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Random backpressure on the result side, except in the quiet phase
    always @(negedge i_clk) begin
        m_axis_tready <= out_idle_on ? ($urandom_range(0, 99) >= IDLE_PCT) : 1'b1;
    end

    // Sample both ports, predict, check, and watch for a hang
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_frame(s_axis_tdata[3:0]);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_state(m_axis_tdata[1:0]);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic send_frame(input logic [3:0] fingers);
        while (in_idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, fingers};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [IDX_BITS-1:0] idx, input logic [DATA_BITS-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        sb.set_reg(idx, val);
        @(negedge i_clk);
    endtask

    // Stop offering beats, then wait for every pending result
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge i_clk);
    endtask

    initial begin
        logic [3:0]          directed [25];
        logic [DATA_BITS-1:0] val;
        int                  count;
        int                  cls;
        int                  run_len;

        // default thresholds: enter one, early two, others; the closing zeros stay below the idle hold
        directed = '{4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
                     4'd2, 4'd2, 4'd2, 4'd2, 4'd2,
                     4'd15, 4'd3, 4'd4, 4'd8, 4'd7, 4'd9, 4'd14,
                     4'd0, 4'd0, 4'd0, 4'd0};

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed[i])
            send_frame(directed[i]);

        for (int phase = 0; phase < PHASES; phase++) begin
            drain();
            if (phase != 0) begin
                for (int r = REG_ONE_HOLD; r <= REG_OTHERS_HOLD; r++) begin
                    case (phase)
                        1:       val = 8'd1;
                        2:       val = 8'd255;
                        3:       val = 8'd0;
                        default: val = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255))
                                                                   : 8'($urandom_range(1, 16));
                    endcase
                    write_reg(r[IDX_BITS-1:0], val);
                end
                write_reg(REG_UNUSED_A, 8'($urandom_range(0, 255)));
                write_reg(REG_UNUSED_B, 8'($urandom_range(0, 255)));
                i_cfg_wr_en <= 1'b0;
            end
            settings++;
            in_idle_on  = (phase != QUIET_PHASE);
            out_idle_on = (phase != QUIET_PHASE);

            count = 0;
            while (count < FRAMES_PER_PHS) begin
                if ($urandom_range(0, 99) < 25) begin
                    send_frame(4'($urandom_range(0, 15)));
                    count++;
                end else begin
                    // hold one class for a while; the odd long run hits saturation
                    cls = $urandom_range(0, 3);
                    run_len = ($urandom_range(0, 14) == 0) ? $urandom_range(250, 300)
                                                           : $urandom_range(1, 24);
                    for (int i = 0; i < run_len; i++) begin
                        send_frame(4'((cls == 3) ? $urandom_range(3, 15) : cls));
                        count++;
                    end
                end
            end
        end

        drain();
        repeat (4) @(negedge i_clk);
        if (sb.pending() != 0) begin
            $error("%0d gesture_state results never arrived", sb.pending());
            sb.errors++;
        end

        $display("Ran %0d frames over %0d threshold settings, %0d results checked.",
                 sb.frames, settings, sb.checked);
        $display("Expected states idle/one/two/others: %0d/%0d/%0d/%0d.",
                 sb.seen[ST_IDLE], sb.seen[ST_ONE], sb.seen[ST_TWO], sb.seen[ST_OTHERS]);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== gesture_count_debouncer.f =====
rtl/core/gcd_pkg.sv
rtl/core/gcd_update.sv
rtl/core/gesture_count_debouncer.sv
rtl/core/gcd_checker.sv
tb/sv/tb_gesture_count_debouncer.sv
